// ----- rtl/segment_square_intersection_assert.svh -----
// assertion macros shared by the checker of the segment versus square test
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef SEGMENT_SQUARE_INTERSECTION_ASSERT_SVH
`define SEGMENT_SQUARE_INTERSECTION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment square check failed");

// antecedent implies consequent in the next cycle
`define SSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment square check failed");

`endif

// ----- rtl/ssi_pkg.sv -----
// shared types and constants of the segment versus square intersection test
// no dependencies
`default_nettype none

package ssi_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  localparam int unsigned CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CENTER_X  = 2'd0,
    CFG_CENTER_Y  = 2'd1,
    CFG_HALF_SIZE = 2'd2
  } cfg_reg_e;

  // output transaction: hit in bit 0, edge mask in bits 4:1, zero padded
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_HIT_BIT = 0;
  localparam int unsigned OUT_MASK_LO = 1;
  localparam int unsigned OUT_MASK_HI = 4;

  localparam int unsigned PIPE_DEPTH = 4;

endpackage

`default_nettype wire

// ----- rtl/ssi_edge.sv -----
// four stage test of one segment against one square edge
// depends on ssi_pkg
`default_nettype none

module ssi_edge #(
  parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] p1_i,
  input  wire logic signed [COORD_WIDTH-1:0] q1_i,
  input  wire logic signed [COORD_WIDTH-1:0] p2_i,
  input  wire logic signed [COORD_WIDTH-1:0] q2_i,
  input  wire logic signed [COORD_WIDTH:0]   k_i,
  input  wire logic signed [COORD_WIDTH:0]   lo_i,
  input  wire logic signed [COORD_WIDTH:0]   hi_i,
  input  wire logic                          empty_i,
  output logic                               hit_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned NW = COORD_WIDTH + 2;
  localparam int unsigned PW = 2 * COORD_WIDTH + 4;

  // stage 1: differences
  logic signed [DW-1:0] dp1_d, dp1_q, dq1_d, dq1_q;
  logic signed [NW-1:0] n1_d, n1_q, a1_d, a1_q, b1_d, b1_q;
  logic                 skip1_q;

  assign dp1_d = DW'(p2_i) - DW'(p1_i);
  assign dq1_d = DW'(q2_i) - DW'(q1_i);
  assign n1_d  = NW'(k_i) - NW'(p1_i);
  assign a1_d  = NW'(lo_i) - NW'(q1_i);
  assign b1_d  = NW'(hi_i) - NW'(q1_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp1_q   <= dp1_d;
      dq1_q   <= dq1_d;
      n1_q    <= n1_d;
      a1_q    <= a1_d;
      b1_q    <= b1_d;
      skip1_q <= empty_i;
    end
  end

  // stage 2: orient so the direction across the edge is positive, range check
  logic                 flip;
  logic signed [NW-1:0] dp2_d, dp2_q, n2_d, n2_q, a2_q, b2_q;
  logic signed [DW-1:0] dq2_q;
  logic                 skip2_d, skip2_q;

  assign flip    = dp1_q[DW-1];
  assign dp2_d   = flip ? -NW'(dp1_q) : NW'(dp1_q);
  assign n2_d    = flip ? -n1_q : n1_q;
  assign skip2_d = skip1_q || (dp1_q == '0) || n2_d[NW-1] || (n2_d > dp2_d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dp2_q   <= dp2_d;
      n2_q    <= n2_d;
      dq2_q   <= dq1_q;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      skip2_q <= skip2_d;
    end
  end

  // stage 3: cross products
  logic signed [PW-1:0] pa_d, pa_q, pn_d, pn_q, pb_d, pb_q;
  logic                 skip3_q;

  assign pa_d = PW'(a2_q) * PW'(dp2_q);
  assign pn_d = PW'(n2_q) * PW'(dq2_q);
  assign pb_d = PW'(b2_q) * PW'(dp2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= pa_d;
      pn_q    <= pn_d;
      pb_q    <= pb_d;
      skip3_q <= skip2_q;
    end
  end

  // stage 4: crossing point within the edge span
  logic hit_d, hit_q;

  assign hit_d = !skip3_q && (pa_q <= pn_q) && (pn_q <= pb_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

// ----- rtl/segment_square_intersection.sv -----
// segment versus axis-aligned square edge test, top level
// depends on ssi_pkg and ssi_edge
//
// usage:
//   s_axis carries one segment per transaction: start_x, start_y, end_x, end_y,
//   each COORD_WIDTH bits signed Q12.4, packed from the lowest bit up.
//   m_axis returns one result per segment: hit in bit 0, edge mask in bits 4:1
//   (bit0 left, bit1 top, bit2 bottom, bit3 right).
//   the cfg channel writes square center x (0), center y (1) and half size (2);
//   it is always ready, and the user must write it only while no segment is in
//   flight; the block itself does not enforce this.
// pipeline: four register stages between s_axis and m_axis.
// throughput: one segment per cycle while m_axis is not stalled; the four stages of the edge test
//   (differences, orientation, cross products, compare) have no feedback.
// stall: while m_axis is stalled with a result waiting, the whole pipeline
//   holds and s_axis_tready_o drops; nothing is lost or repeated.
// reset: asynchronous, active low; clears the pipeline valid bits and sets
//   the square registers to zero, which makes every edge miss.
`default_nettype none

module segment_square_intersection #(
  parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // start_x, start_y, end_x, end_y, zero padded
  input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // hit, edge_mask, zero padded
  output logic [ssi_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ssi_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [COORD_WIDTH-1:0]            cfg_data_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned HW    = COORD_WIDTH - 2;
  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned DEPTH = ssi_pkg::PIPE_DEPTH;
  localparam int unsigned MW    = ssi_pkg::OUT_MASK_HI - ssi_pkg::OUT_MASK_LO + 1;

  // configuration registers
  logic signed [CW-1:0] cx_q, cy_q;
  logic        [HW-1:0] h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      h_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        ssi_pkg::CFG_CENTER_X:  cx_q <= cfg_data_i;
        ssi_pkg::CFG_CENTER_Y:  cy_q <= cfg_data_i;
        ssi_pkg::CFG_HALF_SIZE: h_q  <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // square edges
  logic signed [DW-1:0] h_ext, left, right, top, bottom;
  logic                 empty;

  assign h_ext  = DW'($signed({1'b0, h_q}));
  assign left   = DW'(cx_q) - h_ext;
  assign right  = DW'(cx_q) + h_ext;
  assign top    = DW'(cy_q) - h_ext;
  assign bottom = DW'(cy_q) + h_ext;
  assign empty  = (h_q == '0);

  // input unpacking
  logic signed [CW-1:0] x1, y1, x2, y2;

  assign x1 = s_axis_tdata_i[CW-1:0];
  assign y1 = s_axis_tdata_i[2*CW-1:CW];
  assign x2 = s_axis_tdata_i[3*CW-1:2*CW];
  assign y2 = s_axis_tdata_i[4*CW-1:3*CW];

  // pipeline control
  logic [DEPTH-1:0] vld_d, vld_q;
  logic             adv;

  assign adv             = !vld_q[DEPTH-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign vld_d           = {vld_q[DEPTH-2:0], s_axis_tvalid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // edge tests
  logic [MW-1:0] mask;

  ssi_edge #(.COORD_WIDTH(COORD_WIDTH)) u_left (
    .clk_i, .en_i(adv),
    .p1_i(x1), .q1_i(y1), .p2_i(x2), .q2_i(y2),
    .k_i(left), .lo_i(top), .hi_i(bottom), .empty_i(empty),
    .hit_o(mask[0])
  );

  ssi_edge #(.COORD_WIDTH(COORD_WIDTH)) u_top (
    .clk_i, .en_i(adv),
    .p1_i(y1), .q1_i(x1), .p2_i(y2), .q2_i(x2),
    .k_i(top), .lo_i(left), .hi_i(right), .empty_i(empty),
    .hit_o(mask[1])
  );

  ssi_edge #(.COORD_WIDTH(COORD_WIDTH)) u_bottom (
    .clk_i, .en_i(adv),
    .p1_i(y1), .q1_i(x1), .p2_i(y2), .q2_i(x2),
    .k_i(bottom), .lo_i(left), .hi_i(right), .empty_i(empty),
    .hit_o(mask[2])
  );

  ssi_edge #(.COORD_WIDTH(COORD_WIDTH)) u_right (
    .clk_i, .en_i(adv),
    .p1_i(x1), .q1_i(y1), .p2_i(x2), .q2_i(y2),
    .k_i(right), .lo_i(top), .hi_i(bottom), .empty_i(empty),
    .hit_o(mask[3])
  );

  // output
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[ssi_pkg::OUT_HIT_BIT] = |mask;
    m_axis_tdata_o[ssi_pkg::OUT_MASK_HI:ssi_pkg::OUT_MASK_LO] = mask;
  end

  assign m_axis_tvalid_o = vld_q[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/ssi_checker.sv -----
// port level checks of the segment versus square test, bound to the top level
// depends on ssi_pkg and segment_square_intersection_assert.svh
`default_nettype none
`include "segment_square_intersection_assert.svh"

module ssi_checker #(
  parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               s_axis_tvalid_i,
  input wire logic                               s_axis_tready_o,
  // start_x, start_y, end_x, end_y, zero padded
  input wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  input wire logic                               m_axis_tvalid_o,
  input wire logic                               m_axis_tready_i,
  // hit, edge_mask, zero padded
  input wire logic [ssi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input wire logic                               cfg_valid_i,
  input wire logic                               cfg_ready_o,
  input wire logic [ssi_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input wire logic [COORD_WIDTH-1:0]             cfg_data_i
);

  logic unused_ok;
  assign unused_ok = s_axis_tvalid_i ^ (|s_axis_tdata_i) ^ cfg_valid_i ^ cfg_ready_o ^
                     (|cfg_addr_i) ^ (|cfg_data_i);

  // a stalled result stays put
  `SSI_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // the hit flag is the or of the edge mask
  `SSI_ASSERT_SAME(a_hit_is_or, m_axis_tvalid_o,
    m_axis_tdata_o[ssi_pkg::OUT_HIT_BIT] ==
    (|m_axis_tdata_o[ssi_pkg::OUT_MASK_HI:ssi_pkg::OUT_MASK_LO]))

  // input side only stalls while a result waits on a stalled receiver
  `SSI_ASSERT_SAME(a_ready_free, !m_axis_tvalid_o || m_axis_tready_i, s_axis_tready_o)

endmodule

bind segment_square_intersection ssi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ssi_checker (.*);

`default_nettype wire

// ----- bench/segment_square_intersection_tb.sv -----
// self-checking bench for segment_square_intersection: segments in, edge hit masks out
// depends on ssi_pkg and the segment_square_intersection rtl
`timescale 1ns / 1ps

module segment_square_intersection_tb;

  localparam int CW = 16;
  localparam int NUM_PHASES = 10;
  localparam int SEGS_PER_PHASE = 50;
  localparam longint CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic       hit;
    logic [3:0] mask;
  } edge_result_t;

  class edge_hit_tracker;
    longint cx, cy, h;
    edge_result_t pending_masks[$];
    int errors, results, hits;

    function new();
      cx = 0;
      cy = 0;
      h = 0;
      errors = 0;
      results = 0;
      hits = 0;
    endfunction

    function void set_reg(ssi_pkg::cfg_reg_e idx, logic [CW-1:0] val);
      case (idx)
        ssi_pkg::CFG_CENTER_X: cx = longint'($signed(val));
        ssi_pkg::CFG_CENTER_Y: cy = longint'($signed(val));
        ssi_pkg::CFG_HALF_SIZE: h = longint'(val[13:0]);
        default: ;
      endcase
    endfunction

    // exact test of one edge on line p = k, q spanning lo..hi
    function bit edge_crossed(longint p1, longint q1, longint p2, longint q2,
                              longint k, longint lo, longint hi);
      longint dp, dq, n;
      dp = p2 - p1;
      dq = q2 - q1;
      n = k - p1;
      if (dp == 0 || lo == hi) return 1'b0;
      if (dp < 0) begin
        dp = -dp;
        n = -n;
      end
      if (n < 0 || n > dp) return 1'b0;
      return ((lo - q1) * dp <= n * dq) && (n * dq <= (hi - q1) * dp);
    endfunction

    function void note_segment(logic [4*CW-1:0] seg);
      longint x1, y1, x2, y2, left, right, top, bottom;
      edge_result_t r;
      x1 = longint'($signed(seg[CW-1:0]));
      y1 = longint'($signed(seg[2*CW-1:CW]));
      x2 = longint'($signed(seg[3*CW-1:2*CW]));
      y2 = longint'($signed(seg[4*CW-1:3*CW]));
      left = cx - h;
      right = cx + h;
      top = cy - h;
      bottom = cy + h;
      r.mask[0] = edge_crossed(x1, y1, x2, y2, left, top, bottom);
      r.mask[1] = edge_crossed(y1, x1, y2, x2, top, left, right);
      r.mask[2] = edge_crossed(y1, x1, y2, x2, bottom, left, right);
      r.mask[3] = edge_crossed(x1, y1, x2, y2, right, top, bottom);
      r.hit = |r.mask;
      pending_masks = {pending_masks, r};
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [ssi_pkg::OUT_TDATA_W-1:0] data);
      edge_result_t want;
      if (pending_masks.size() == 0) begin
        report($sformatf("result 0x%02h with no segment pending", data));
        return;
      end
      want = pending_masks.pop_front();
      results++;
      if (want.hit) hits++;
      if (data[ssi_pkg::OUT_HIT_BIT] !== want.hit)
        report($sformatf("result %0d hit %b, expected %b", results,
                         data[ssi_pkg::OUT_HIT_BIT], want.hit));
      if (data[ssi_pkg::OUT_MASK_HI:ssi_pkg::OUT_MASK_LO] !== want.mask)
        report($sformatf("result %0d edge mask %b, expected %b", results,
                         data[ssi_pkg::OUT_MASK_HI:ssi_pkg::OUT_MASK_LO], want.mask));
    endtask

    function int pending();
      return pending_masks.size();
    endfunction
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [4*CW-1:0]                  s_axis_tdata_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [ssi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [ssi_pkg::CFG_ADDR_W-1:0]   cfg_addr_i;
  logic [CW-1:0]                    cfg_data_i;

  edge_hit_tracker board = new();
  bit gaps_on;
  bit stalls_on;
  longint cycles;
  longint cur_cx, cur_cy, cur_h;

  segment_square_intersection #(.COORD_WIDTH(CW)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(5, 30));
  endfunction

  function automatic logic [CW-1:0] to_coord(longint v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[CW-1:0];
  endfunction

  function automatic longint near(longint c, longint hs);
    longint span;
    span = 2 * hs + 32;
    return c - span + longint'($urandom_range(0, 32'(2 * span)));
  endfunction

  // result side: random stalls, some of them long
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_result(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_segment(longint x1, longint y1, longint x2, longint y2);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {to_coord(y2), to_coord(x2), to_coord(y1), to_coord(x1)};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_segment(s_axis_tdata_i);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (ssi_pkg::PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(ssi_pkg::cfg_reg_e idx, longint val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val[CW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val[CW-1:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_square(longint cx, longint cy, longint hs);
    cur_cx = cx;
    cur_cy = cy;
    cur_h = hs;
    write_reg(ssi_pkg::CFG_CENTER_X, cx);
    write_reg(ssi_pkg::CFG_CENTER_Y, cy);
    write_reg(ssi_pkg::CFG_HALF_SIZE, hs);
  endtask

  // mostly segments around the current square, the rest anywhere
  task automatic random_segment();
    longint x1, y1, x2, y2, kx, ky, a, b;
    case ($urandom_range(0, 9))
      0: begin
        x1 = longint'($signed(16'($urandom)));
        y1 = longint'($signed(16'($urandom)));
        x2 = longint'($signed(16'($urandom)));
        y2 = longint'($signed(16'($urandom)));
      end
      1: begin
        x1 = near(cur_cx, cur_h);
        y1 = near(cur_cy, cur_h);
        x2 = x1;
        y2 = y1;
      end
      2: begin
        kx = $urandom_range(0, 1) ? cur_cx + cur_h : cur_cx - cur_h;
        ky = $urandom_range(0, 1) ? cur_cy + cur_h : cur_cy - cur_h;
        a = longint'($urandom_range(0, 400)) - 200;
        b = longint'($urandom_range(0, 400)) - 200;
        x1 = kx + a;
        y1 = ky + b;
        x2 = kx - a;
        y2 = ky - b;
      end
      3: begin
        y1 = $urandom_range(0, 2) == 0 ? cur_cy + ($urandom_range(0, 1) ? cur_h : -cur_h)
                                       : near(cur_cy, cur_h);
        y2 = y1;
        x1 = near(cur_cx, cur_h);
        x2 = near(cur_cx, cur_h);
      end
      4: begin
        x1 = $urandom_range(0, 2) == 0 ? cur_cx + ($urandom_range(0, 1) ? cur_h : -cur_h)
                                       : near(cur_cx, cur_h);
        x2 = x1;
        y1 = near(cur_cy, cur_h);
        y2 = near(cur_cy, cur_h);
      end
      5: begin
        x1 = near(cur_cx, cur_h);
        y1 = near(cur_cy, cur_h);
        if ($urandom_range(0, 1)) begin
          x2 = $urandom_range(0, 1) ? cur_cx + cur_h : cur_cx - cur_h;
          y2 = cur_cy - cur_h + longint'($urandom_range(0, 32'(2 * cur_h)));
        end else begin
          y2 = $urandom_range(0, 1) ? cur_cy + cur_h : cur_cy - cur_h;
          x2 = cur_cx - cur_h + longint'($urandom_range(0, 32'(2 * cur_h)));
        end
      end
      default: begin
        x1 = near(cur_cx, cur_h);
        y1 = near(cur_cy, cur_h);
        x2 = near(cur_cx, cur_h);
        y2 = near(cur_cy, cur_h);
      end
    endcase
    send_segment(x1, y1, x2, y2);
  endtask

  initial begin
    longint hs;
    cycles = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    cur_cx = 0;
    cur_cy = 0;
    cur_h = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = ssi_pkg::CFG_CENTER_X;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // square registers at reset: zero half size, nothing can hit
    send_segment(0, 0, 0, 0);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768);
    send_segment(-1, 1, 1, -1);
    stop_sending();
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      gaps_on = (p % 3) != 0;
      stalls_on = (p % 3) != 1;
      case (p)
        0: set_square(0, 0, 160);
        1: set_square(32767, -32768, 16383);
        2: set_square(-32768, 32767, 16383);
        3: set_square(0, 0, 0);
        4: set_square(0, 0, 1);
        default: begin
          case ($urandom_range(0, 3))
            0: hs = longint'($urandom_range(0, 16383));
            1: hs = longint'($urandom_range(0, 64));
            default: hs = longint'($urandom_range(1, 2048));
          endcase
          set_square(longint'($urandom_range(0, 65535)) - 32768,
                     longint'($urandom_range(0, 65535)) - 32768, hs);
        end
      endcase
      if (p == 0) begin
        send_segment(-320, 0, 320, 0);
        send_segment(0, -320, 0, 320);
        send_segment(-320, -320, 320, 320);
        send_segment(-320, -160, 320, -160);
        send_segment(-160, -320, -160, 320);
        send_segment(-50, -50, 50, 50);
        send_segment(-160, 0, -160, 0);
        send_segment(-320, 0, -160, 0);
        send_segment(-200, -120, -120, -200);
        send_segment(-32768, -32768, 32767, 32767);
        send_segment(32767, -32768, -32768, 32767);
        send_segment(-32768, 0, 32767, 0);
        send_segment(0, 32767, 0, -32768);
        send_segment(400, 0, 500, 100);
        send_segment(-161, 0, -159, 1);
      end
      for (int i = 0; i < SEGS_PER_PHASE; i++) begin
        if (p == 6 && i == SEGS_PER_PHASE / 2) begin
          stop_sending();
          wait_drained();
        end
        random_segment();
      end
      stop_sending();
      wait_drained();
    end

    repeat (4 * ssi_pkg::PIPE_DEPTH) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));
    $display("%0d segments checked against %0d square settings, %0d of them hit an edge",
             board.results, NUM_PHASES + 1, board.hits);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
